// ----- rtl/core/ppvc_pkg.sv -----
// Shared types and constants for the planar velocity controller.
package ppvc_pkg;

    localparam int CoordW   = 32;
    localparam int CfgW     = 24;
    localparam int CfgAddrW = 2;
    localparam int OpW      = 2;
    localparam int MagW     = 33;
    localparam int ProdW    = 57;
    localparam int MulSteps = 24;
    localparam int DivSteps = 57;
    localparam int SqrtSteps = 32;
    localparam int CntW     = 6;

    localparam logic [CfgW-1:0] GainRst = 24'd32768;
    localparam logic [CfgW-1:0] MaxSpeedRst = 24'd65536;
    localparam logic [CfgW-1:0] TolRst = 24'd13107;
    localparam logic [CfgW-1:0] MinSpeedRst = 24'd19661;

    typedef enum logic [OpW-1:0] {
        OP_GOAL = 2'd0,
        OP_MEAS = 2'd1,
        OP_TICK = 2'd2,
        OP_RSVD = 2'd3
    } op_t;

    typedef enum logic [CfgAddrW-1:0] {
        REG_GAIN     = 2'd0,
        REG_MAX      = 2'd1,
        REG_TOL      = 2'd2,
        REG_MIN      = 2'd3
    } cfg_idx_t;

    typedef enum logic [4:0] {
        U_NONE, U_ERR, U_PX, U_PY, U_LIM, U_NX, U_QX, U_NY, U_QY,
        U_SX, U_SY, U_MN2, U_RT, U_BX, U_BQX, U_BY, U_BQY
    } uop_t;

    typedef struct packed {
        logic start;
        uop_t uop;
        logic ld_goal;
        logic ld_meas;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic done;
        logic limited;
        logic boost;
        logic reached;
    } dp_stat_t;

endpackage

// ----- rtl/core/planar_p_velocity_controller_core.sv -----
// Top level of the planar proportional velocity controller.
//
// Input items arrive on s_axis: tuser carries the opcode (goal, position,
// tick), tdata the x and y coordinates. A goal is kept only once a position
// has been seen. A tick with an active goal yields one item on m_axis with
// the x and y velocity and the reached flag; other items yield nothing.
// Registers are to be written through cfg_we/cfg_addr/cfg_data only while
// idle; the block itself does not enforce this. A tick runs a sequencer
// over one shared shift-add multiplier (24 steps), a restoring divider (57
// steps) and a square root unit (32 steps). The plain case runs the error,
// the gain products, the limit check and the squares; the speed limit adds
// a multiply and divide per axis, the minimum speed scaling a square root
// and a multiply and divide per axis. s_axis_tready is high only between
// ticks. The result sits in an output register; a stalled receiver holds
// it while goal and position items are still taken, and the next tick's
// result waits for it. Reset clears the goal and position flags, loads the
// register defaults and drops m_axis_tvalid.
module planar_p_velocity_controller_core
    import ppvc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [63:0]         s_axis_tdata,   // coord_x, coord_y
    input  logic [OpW-1:0]      s_axis_tuser,   // opcode
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [71:0]         m_axis_tdata,   // vel_x, vel_y, reached, zero pad
    input  logic                cfg_we,
    input  logic [CfgAddrW-1:0] cfg_addr,
    input  logic [CfgW-1:0]     cfg_data
);

    dp_cmd_t           cmd;
    dp_stat_t          stat;
    logic [CoordW-1:0] vel_x, vel_y;
    logic              reached;

    ppvc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .opcode    (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    ppvc_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .coord_x  (s_axis_tdata[31:0]),
        .coord_y  (s_axis_tdata[63:32]),
        .cmd      (cmd),
        .stat     (stat),
        .vel_x    (vel_x),
        .vel_y    (vel_y),
        .reached  (reached)
    );

    assign m_axis_tdata = {7'd0, reached, vel_y, vel_x};

endmodule

// ----- rtl/core/ppvc_dp.sv -----
// Datapath: goal and position store, shared shift-add multiplier, divider and square root.
module ppvc_dp
    import ppvc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CfgAddrW-1:0] cfg_addr,
    input  logic [CfgW-1:0]     cfg_data,
    input  logic [CoordW-1:0]   coord_x,
    input  logic [CoordW-1:0]   coord_y,
    input  dp_cmd_t             cmd,
    output dp_stat_t            stat,
    output logic [CoordW-1:0]   vel_x,
    output logic [CoordW-1:0]   vel_y,
    output logic                reached
);

    logic [CfgW-1:0]   gain_reg, max_reg, tol_reg, min_reg;
    logic [CoordW-1:0] tgt_x_reg, tgt_y_reg, meas_x_reg, meas_y_reg;
    logic [MagW-1:0]   ax_reg, ay_reg, m_reg;
    logic              negx_reg, negy_reg, reached_reg, limited_reg;
    logic [ProdW-1:0]  px_reg, py_reg, vx_reg, vy_reg, num_reg;
    logic [48:0]       s2_reg;
    logic [47:0]       mn2_reg;
    logic [31:0]       r_reg;
    uop_t              uop_reg;
    logic              busy_reg, done_reg;
    logic [CntW-1:0]   cnt_reg;
    logic [ProdW-1:0]  p_reg, p_next;
    logic [MagW-1:0]   mcand_reg, mul_a;
    logic [CfgW-1:0]   mul_b;
    logic [ProdW-1:0]  dvd_reg, dvd_next;
    logic [MagW-1:0]   rem_reg, rem_next, dvs_reg;
    logic [63:0]       sx_reg, sres_reg, sbit_reg, sx_next, sres_next;
    logic [MagW:0]     dx, dy, msum, rem_sh;
    logic [MagW-1:0]   ax, ay;
    logic [63:0]       trial;
    logic [39:0]       lim;
    logic [CoordW-1:0] vel_x_reg, vel_y_reg;
    logic              out_reached_reg;

    function automatic logic [CoordW-1:0] with_sign(input logic [ProdW-1:0] m,
                                                    input logic neg);
        logic [CoordW-1:0] r;
        if (m > ProdW'(32'h7FFFFFFF))
            r = neg ? 32'h80000000 : 32'h7FFFFFFF;
        else
            r = neg ? (32'd0 - m[CoordW-1:0]) : m[CoordW-1:0];
        return r;
    endfunction

    assign dx = {{2{tgt_x_reg[31]}}, tgt_x_reg} - {{2{meas_x_reg[31]}}, meas_x_reg};
    assign dy = {{2{tgt_y_reg[31]}}, tgt_y_reg} - {{2{meas_y_reg[31]}}, meas_y_reg};
    assign ax = dx[MagW] ? MagW'(-dx) : dx[MagW-1:0];
    assign ay = dy[MagW] ? MagW'(-dy) : dy[MagW-1:0];
    assign lim = {max_reg, 16'd0};

    always_comb
    begin
        mul_a = ax_reg;
        mul_b = gain_reg;
        case (cmd.uop)
            U_PX:  begin mul_a = ax_reg;               mul_b = gain_reg;       end
            U_PY:  begin mul_a = ay_reg;               mul_b = gain_reg;       end
            U_NX:  begin mul_a = ax_reg;               mul_b = max_reg;        end
            U_NY:  begin mul_a = ay_reg;               mul_b = max_reg;        end
            U_SX:  begin mul_a = vx_reg[MagW-1:0];     mul_b = vx_reg[23:0];   end
            U_SY:  begin mul_a = vy_reg[MagW-1:0];     mul_b = vy_reg[23:0];   end
            U_MN2: begin mul_a = {9'd0, min_reg};      mul_b = min_reg;        end
            U_BX:  begin mul_a = vx_reg[MagW-1:0];     mul_b = min_reg;        end
            U_BY:  begin mul_a = vy_reg[MagW-1:0];     mul_b = min_reg;        end
            default: ;
        endcase
    end

    assign msum   = {1'b0, p_reg[ProdW-1:24]} + (p_reg[0] ? {1'b0, mcand_reg} : '0);
    assign p_next = {msum, p_reg[23:1]};

    assign rem_sh = {rem_reg, dvd_reg[ProdW-1]};
    always_comb
    begin
        if (rem_sh >= {1'b0, dvs_reg})
        begin
            rem_next = MagW'(rem_sh - {1'b0, dvs_reg});
            dvd_next = {dvd_reg[ProdW-2:0], 1'b1};
        end
        else
        begin
            rem_next = rem_sh[MagW-1:0];
            dvd_next = {dvd_reg[ProdW-2:0], 1'b0};
        end
    end

    assign trial = sres_reg + sbit_reg;
    always_comb
    begin
        if (sx_reg >= trial)
        begin
            sx_next   = sx_reg - trial;
            sres_next = (sres_reg >> 1) + sbit_reg;
        end
        else
        begin
            sx_next   = sx_reg;
            sres_next = sres_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg   <= GainRst;
            max_reg    <= MaxSpeedRst;
            tol_reg    <= TolRst;
            min_reg    <= MinSpeedRst;
            tgt_x_reg  <= '0;
            tgt_y_reg  <= '0;
            meas_x_reg <= '0;
            meas_y_reg <= '0;
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
            uop_reg    <= U_NONE;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_addr))
                    REG_GAIN: gain_reg <= cfg_data;
                    REG_MAX:  max_reg  <= cfg_data;
                    REG_TOL:  tol_reg  <= cfg_data;
                    REG_MIN:  min_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.ld_goal)
            begin
                tgt_x_reg <= coord_x;
                tgt_y_reg <= coord_y;
            end
            if (cmd.ld_meas)
            begin
                meas_x_reg <= coord_x;
                meas_y_reg <= coord_y;
            end
            done_reg <= busy_reg && (cnt_reg == '0);
            if (cmd.start)
            begin
                uop_reg  <= cmd.uop;
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                case (cmd.uop)
                    U_PX, U_PY, U_NX, U_NY, U_SX, U_SY, U_MN2, U_BX, U_BY:
                        cnt_reg <= CntW'(MulSteps);
                    U_QX, U_QY, U_BQX, U_BQY:
                        cnt_reg <= CntW'(DivSteps);
                    U_RT:
                        cnt_reg <= CntW'(SqrtSteps);
                    default: ;
                endcase
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                    busy_reg <= 1'b0;
                else
                    cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            mcand_reg <= mul_a;
            p_reg     <= {33'd0, mul_b};
            rem_reg   <= '0;
            case (cmd.uop)
                U_ERR:
                begin
                    ax_reg      <= ax;
                    ay_reg      <= ay;
                    negx_reg    <= dx[MagW];
                    negy_reg    <= dy[MagW];
                    reached_reg <= (ax < {9'd0, tol_reg}) && (ay < {9'd0, tol_reg});
                end
                U_LIM:
                begin
                    limited_reg <= (px_reg > ProdW'(lim)) || (py_reg > ProdW'(lim));
                    m_reg       <= (ax_reg > ay_reg) ? ax_reg : ay_reg;
                    vx_reg      <= px_reg >> 16;
                    vy_reg      <= py_reg >> 16;
                end
                U_QX, U_QY:
                begin
                    dvd_reg <= num_reg;
                    dvs_reg <= m_reg;
                end
                U_BQX, U_BQY:
                begin
                    dvd_reg <= num_reg << 8;
                    dvs_reg <= {1'b0, r_reg};
                end
                U_RT:
                begin
                    sx_reg   <= {s2_reg[47:0], 16'd0};
                    sres_reg <= '0;
                    sbit_reg <= 64'd1 << 62;
                end
                default: ;
            endcase
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                p_reg    <= p_next;
                rem_reg  <= rem_next;
                dvd_reg  <= dvd_next;
                sx_reg   <= sx_next;
                sres_reg <= sres_next;
                sbit_reg <= sbit_reg >> 2;
            end
            else
            begin
                case (uop_reg)
                    U_PX:  px_reg  <= p_reg;
                    U_PY:  py_reg  <= p_reg;
                    U_NX, U_NY, U_BX, U_BY: num_reg <= p_reg;
                    U_SX:  s2_reg  <= p_reg[48:0];
                    U_SY:  s2_reg  <= s2_reg + p_reg[48:0];
                    U_MN2: mn2_reg <= p_reg[47:0];
                    U_QX, U_BQX: vx_reg <= dvd_reg;
                    U_QY, U_BQY: vy_reg <= dvd_reg;
                    U_RT:  r_reg   <= sres_reg[31:0];
                    default: ;
                endcase
            end
        end
        if (cmd.emit)
        begin
            vel_x_reg       <= with_sign(vx_reg, negx_reg);
            vel_y_reg       <= with_sign(vy_reg, negy_reg);
            out_reached_reg <= reached_reg;
        end
    end

    assign stat.done    = done_reg;
    assign stat.limited = limited_reg;
    assign stat.boost   = (s2_reg != '0) && (s2_reg < {1'b0, mn2_reg});
    assign stat.reached = reached_reg;
    assign vel_x   = vel_x_reg;
    assign vel_y   = vel_y_reg;
    assign reached = out_reached_reg;

endmodule

// ----- rtl/core/ppvc_ctrl.sv -----
// Controller: item decode, goal state and the step sequencer for one tick.
module ppvc_ctrl
    import ppvc_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [OpW-1:0] opcode,
    output logic           out_valid,
    input  logic           out_ready,
    output dp_cmd_t        cmd,
    input  dp_stat_t       stat
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_ERR, ST_PX, ST_PY, ST_LIM, ST_NX, ST_QX, ST_NY, ST_QY,
        ST_SX, ST_SY, ST_MN2, ST_RT, ST_BX, ST_BQX, ST_BY, ST_BQY, ST_EMIT
    } state_t;

    state_t state_reg;
    logic   issued_reg, start_reg, goal_active_reg, pos_seen_reg, out_valid_reg;
    uop_t   uop_reg, step_uop;
    logic   accept, emit;

    always_comb
    begin
        unique case (state_reg)
            ST_ERR:  step_uop = U_ERR;
            ST_PX:   step_uop = U_PX;
            ST_PY:   step_uop = U_PY;
            ST_LIM:  step_uop = U_LIM;
            ST_NX:   step_uop = U_NX;
            ST_QX:   step_uop = U_QX;
            ST_NY:   step_uop = U_NY;
            ST_QY:   step_uop = U_QY;
            ST_SX:   step_uop = U_SX;
            ST_SY:   step_uop = U_SY;
            ST_MN2:  step_uop = U_MN2;
            ST_RT:   step_uop = U_RT;
            ST_BX:   step_uop = U_BX;
            ST_BQX:  step_uop = U_BQX;
            ST_BY:   step_uop = U_BY;
            ST_BQY:  step_uop = U_BQY;
            default: step_uop = U_NONE;
        endcase
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign emit     = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);

    assign cmd.start   = start_reg;
    assign cmd.uop     = uop_reg;
    assign cmd.ld_goal = accept && (op_t'(opcode) == OP_GOAL) && pos_seen_reg;
    assign cmd.ld_meas = accept && (op_t'(opcode) == OP_MEAS);
    assign cmd.emit    = emit;
    assign out_valid   = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            issued_reg      <= 1'b0;
            start_reg       <= 1'b0;
            uop_reg         <= U_NONE;
            goal_active_reg <= 1'b0;
            pos_seen_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            start_reg <= 1'b0;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (state_reg == ST_IDLE)
            begin
                if (accept)
                begin
                    case (op_t'(opcode))
                        OP_GOAL: if (pos_seen_reg) goal_active_reg <= 1'b1;
                        OP_MEAS: pos_seen_reg <= 1'b1;
                        OP_TICK: if (goal_active_reg) state_reg <= ST_ERR;
                        default: ;
                    endcase
                end
            end
            else if (state_reg == ST_EMIT)
            begin
                if (emit)
                    state_reg <= ST_IDLE;
            end
            else if (!issued_reg)
            begin
                issued_reg <= 1'b1;
                start_reg  <= 1'b1;
                uop_reg    <= step_uop;
            end
            else if (stat.done)
            begin
                issued_reg <= 1'b0;
                unique case (state_reg)
                    ST_ERR:
                    begin
                        if (stat.reached)
                            goal_active_reg <= 1'b0;
                        state_reg <= ST_PX;
                    end
                    ST_PX:  state_reg <= ST_PY;
                    ST_PY:  state_reg <= ST_LIM;
                    ST_LIM: state_reg <= stat.limited ? ST_NX : ST_SX;
                    ST_NX:  state_reg <= ST_QX;
                    ST_QX:  state_reg <= ST_NY;
                    ST_NY:  state_reg <= ST_QY;
                    ST_QY:  state_reg <= ST_SX;
                    ST_SX:  state_reg <= ST_SY;
                    ST_SY:  state_reg <= ST_MN2;
                    ST_MN2: state_reg <= stat.boost ? ST_RT : ST_EMIT;
                    ST_RT:  state_reg <= ST_BX;
                    ST_BX:  state_reg <= ST_BQX;
                    ST_BQX: state_reg <= ST_BY;
                    ST_BY:  state_reg <= ST_BQY;
                    ST_BQY: state_reg <= ST_EMIT;
                    default: state_reg <= ST_IDLE;
                endcase
            end
        end
    end

endmodule

// ----- tb/tb_planar_p_velocity_controller_core.sv -----
// Testbench for the planar velocity controller: directed and random items checked against a predictor.
module tb_planar_p_velocity_controller_core;
    import ppvc_pkg::*;

    typedef struct packed {
        logic [31:0] vx;
        logic [31:0] vy;
        logic        reached;
    } vel_cmd_t;

    class vel_scoreboard;
        logic [23:0] gain_q, maxv_q, tol_q, minv_q;
        logic signed [32:0] tgt_x, tgt_y, pos_x, pos_y;
        bit goal_on, pos_seen;
        vel_cmd_t pending[$];
        int errors, checked, ticks;

        function void clear();
            gain_q = GainRst;
            maxv_q = MaxSpeedRst;
            tol_q = TolRst;
            minv_q = MinSpeedRst;
            tgt_x = 0;
            tgt_y = 0;
            pos_x = 0;
            pos_y = 0;
            goal_on = 0;
            pos_seen = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [23:0] v);
            case (idx)
                REG_GAIN: gain_q = v;
                REG_MAX:  maxv_q = v;
                REG_TOL:  tol_q = v;
                REG_MIN:  minv_q = v;
                default: ;
            endcase
        endfunction

        function logic [63:0] root(logic [63:0] x);
            logic [63:0] res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > x)
                b = b >> 2;
            while (b != 0)
            begin
                if (x >= res + b)
                begin
                    x = x - (res + b);
                    res = (res >> 1) + b;
                end
                else
                    res = res >> 1;
                b = b >> 2;
            end
            return res;
        endfunction

        function logic [31:0] signed_out(logic [63:0] m, bit neg);
            if (m > 64'h7FFF_FFFF)
                return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            return neg ? -m[31:0] : m[31:0];
        endfunction

        function void note_input(op_t op, logic [31:0] cx, logic [31:0] cy);
            logic signed [32:0] dx, dy;
            logic [63:0] ax, ay, lim, mx, vxm, vym, s2, r, mn;
            vel_cmd_t c;
            case (op)
                OP_GOAL:
                    if (pos_seen)
                    begin
                        tgt_x = $signed(cx);
                        tgt_y = $signed(cy);
                        goal_on = 1;
                    end
                OP_MEAS:
                begin
                    pos_x = $signed(cx);
                    pos_y = $signed(cy);
                    pos_seen = 1;
                end
                OP_TICK:
                    if (goal_on)
                    begin
                        dx = tgt_x - pos_x;
                        dy = tgt_y - pos_y;
                        ax = dx < 0 ? 64'(-dx) : 64'(dx);
                        ay = dy < 0 ? 64'(-dy) : 64'(dy);
                        lim = 64'(maxv_q) << 16;
                        if (ax * gain_q > lim || ay * gain_q > lim)
                        begin
                            mx = ax > ay ? ax : ay;
                            vxm = ax * maxv_q / mx;
                            vym = ay * maxv_q / mx;
                        end
                        else
                        begin
                            vxm = (ax * gain_q) >> 16;
                            vym = (ay * gain_q) >> 16;
                        end
                        c.reached = ax < tol_q && ay < tol_q;
                        if (c.reached)
                            goal_on = 0;
                        s2 = vxm * vxm + vym * vym;
                        mn = minv_q;
                        if (s2 > 0 && s2 < mn * mn)
                        begin
                            r = root(s2 << 16);
                            vxm = ((vxm * mn) << 8) / r;
                            vym = ((vym * mn) << 8) / r;
                        end
                        c.vx = signed_out(vxm, dx < 0);
                        c.vy = signed_out(vym, dy < 0);
                        pending.push_back(c);
                        ticks++;
                    end
                default: ;
            endcase
        endfunction

        function void check_result(logic [71:0] d);
            vel_cmd_t e;
            checked++;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected velocity item %h", d);
                return;
            end
            e = pending.pop_front();
            if (d[31:0] !== e.vx || d[63:32] !== e.vy || d[64] !== e.reached)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp vx=%h vy=%h rch=%b got vx=%h vy=%h rch=%b",
                             e.vx, e.vy, e.reached, d[31:0], d[63:32], d[64]);
            end
        endfunction
    endclass

    logic clk = 0, rst_n = 0;
    logic s_axis_tvalid = 0, s_axis_tready;
    logic [63:0] s_axis_tdata = 0;
    logic [OpW-1:0] s_axis_tuser = 0;
    logic m_axis_tvalid, m_axis_tready = 0;
    logic [71:0] m_axis_tdata;
    logic cfg_we = 0;
    logic [CfgAddrW-1:0] cfg_addr = 0;
    logic [CfgW-1:0] cfg_data = 0;

    int src_idle_pct, sink_stall_pct;
    vel_scoreboard sb;

    always #4 clk = ~clk;

    planar_p_velocity_controller_core u_dut (.*);

    always @(posedge clk)
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end

    task automatic send_item(op_t op, logic [31:0] cx, logic [31:0] cy);
        if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 0;
            @(posedge clk);
            while ($urandom_range(99) < src_idle_pct)
                @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= op;
        s_axis_tdata <= {cy, cx};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_input(op, cx, cy);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (600)
            @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [23:0] v);
        cfg_we <= 1;
        cfg_addr <= idx;
        cfg_data <= v;
        @(posedge clk);
        sb.set_reg(idx, v);
    endtask

    function automatic logic [31:0] near(logic [31:0] base, int span);
        return base + $signed($urandom_range(2 * span) - span);
    endfunction

    task automatic random_phase(int n);
        logic [31:0] px, py;
        int k;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(99);
            px = $urandom;
            py = $urandom;
            if (k < 20)
                send_item(OP_MEAS, $urandom_range(1) ? px : near(0, 300000),
                          $urandom_range(1) ? py : near(0, 300000));
            else if (k < 38)
                send_item(OP_GOAL, $urandom_range(1) ? near(sb.pos_x[31:0], 40000) : px,
                          $urandom_range(1) ? near(sb.pos_y[31:0], 40000) : py);
            else if (k < 95)
                send_item(OP_TICK, $urandom, $urandom);
            else
                send_item(OP_RSVD, px, py);
        end
    endtask

    logic [23:0] extremes[4] = '{24'h0, 24'h1, 24'hFFFFFF, 24'h10000};

    initial
    begin
        sb = new();
        sb.clear();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: goal before position, idle ticks, extremes, reserved op
        send_item(OP_GOAL, 32'h0001_0000, 32'h0001_0000);
        send_item(OP_TICK, 0, 0);
        send_item(OP_RSVD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_MEAS, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(OP_GOAL, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(OP_TICK, 0, 0);
        send_item(OP_MEAS, 0, 0);
        send_item(OP_GOAL, 0, 0);
        send_item(OP_TICK, 0, 0);
        send_item(OP_TICK, 0, 0);
        send_item(OP_GOAL, 32'h0000_1000, 32'hFFFF_F000);
        send_item(OP_TICK, 0, 0);
        send_item(OP_GOAL, 32'h0008_0000, 32'h0000_0100);
        send_item(OP_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_MEAS, 32'h0007_0000, 32'h0000_4000);
        send_item(OP_TICK, 0, 0);
        send_item(OP_GOAL, 32'h8000_0000, 32'h8000_0000);
        send_item(OP_TICK, 0, 0);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 68; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 68; end
                default: begin src_idle_pct = 29; sink_stall_pct = 29; end
            endcase
            if (ph < 4)
            begin
                write_reg(REG_GAIN, ph == 0 ? extremes[2] : extremes[ph % 4]);
                write_reg(REG_MAX, extremes[(ph + 1) % 4]);
                write_reg(REG_TOL, extremes[(ph + 2) % 4]);
                write_reg(REG_MIN, extremes[(ph + 3) % 4]);
            end
            else
            begin
                write_reg(REG_GAIN, 24'($urandom_range(24'hFFFFFF)));
                write_reg(REG_MAX, 24'($urandom_range(24'h3FFFF)));
                write_reg(REG_TOL, 24'($urandom_range(24'h8000)));
                write_reg(REG_MIN, 24'($urandom_range(24'h20000)));
            end
            cfg_we <= 0;
            random_phase(54);
            drain();
        end

        $display("covered %0d velocity results over 8 register settings and 4 flow patterns",
                 sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("end of test: mismatches");
        $finish;
    end
endmodule

// ----- files.f -----
rtl/core/ppvc_pkg.sv
rtl/core/ppvc_dp.sv
rtl/core/ppvc_ctrl.sv
rtl/core/planar_p_velocity_controller_core.sv
tb/tb_planar_p_velocity_controller_core.sv
